[src/fba_pkg.sv]
// ----------------------------------------------------------------------------
// fba_pkg: shared types and constants of the frame bitmap allocator
// Payload structs, controller/datapath command and status bundles, codes and
// the sizing of the frame bitmap and its scan.
// ----------------------------------------------------------------------------
package fba_pkg;

	// Sizing
	localparam int NUM_FRAMES  = 4096;
	localparam int FRAME_W     = 12;
	localparam int STAT_W      = 2;
	localparam int WORD_W      = 32;
	localparam int BIT_W       = 5;
	localparam int MAP_WORDS   = (NUM_FRAMES + WORD_W - 1) / WORD_W;
	localparam int ADDR_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int FIELD_LIMIT = 1 << FRAME_W;
	localparam int SCAN_LIMIT  = (NUM_FRAMES < FIELD_LIMIT) ? NUM_FRAMES : FIELD_LIMIT;
	localparam int SCAN_WORDS  = (SCAN_LIMIT + WORD_W - 1) / WORD_W;
	localparam int LAST_USED   = SCAN_LIMIT - (SCAN_WORDS - 1) * WORD_W;
	localparam int GRP_SIZE    = 8;
	localparam int GROUPS      = (SCAN_WORDS + GRP_SIZE - 1) / GRP_SIZE;
	localparam int GRP_W       = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int GRP_IDX_W   = 3;

	// Command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOOP = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

	// Result selection codes
	localparam logic [1:0] RES_NOOP  = 2'd0;
	localparam logic [1:0] RES_FULL  = 2'd1;
	localparam logic [1:0] RES_ALLOC = 2'd2;
	localparam logic [1:0] RES_FREE  = 2'd3;

	typedef struct packed {
		logic               cmd;
		logic [FRAME_W-1:0] entry_frame;
		logic               kernel_page;
		logic               write_req;
	} fba_in_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_number;
		logic               present;
		logic               writable;
		logic               user_mode;
		logic [STAT_W-1:0]  status;
	} fba_out_t;

	// Controller to datapath
	typedef struct packed {
		logic       load_req;
		logic       scan_clr;
		logic       scan_step;
		logic       rd_entry;
		logic       rd_found;
		logic       mod_alloc;
		logic       mod_free;
		logic       res_load;
		logic [1:0] res_sel;
		logic       out_load;
	} fba_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_free;
		logic req_noop;
		logic grp_hit;
		logic grp_last;
	} fba_stat_t;

	// Bits of the last scanned word that lie beyond the scan limit read as used
	function automatic logic [WORD_W-1:0] last_fill_mask();
		logic [WORD_W-1:0] m;
		m = '0;
		for (int b = 0; b < WORD_W; b++) begin
			if (b >= LAST_USED)
				m[b] = 1'b1;
		end
		return m;
	endfunction

	localparam logic [WORD_W-1:0] LAST_FILL = last_fill_mask();
	localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(SCAN_WORDS - 1);

endpackage

[src/frame_bitmap_allocator_top.sv]
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_top: first-fit page frame allocator
// Keeps one used bit per page frame; allocate takes the lowest free frame,
// free returns a frame to the pool. One result beat per command beat.
//
//   channel  direction  handshake              beat
//   in       input      in_valid / in_ready    fba_in_t  (cmd, entry, flags)
//   out      output     out_valid / out_ready  fba_out_t (frame, bits, status)
//
// Allocate: decode, group scan (eight words of the full-word summary per
// cycle), word read and read-modify-write, then the output register. Free
// commands skip the group scan; no-op commands also skip the word update.
// Reset clears the bitmap at once through per-word written flags; no sweep.
// The output register frees the core: a new command is accepted while the
// previous result waits; the core stalls only if a second result is ready.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_top
	import fba_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  fba_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output fba_out_t out_data
);

	fba_cmd_t  ctl;
	fba_stat_t stat;

	fba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	fba_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (in_data),
		.ctl     (ctl),
		.stat    (stat),
		.out_data(out_data)
	);

endmodule

[src/fba_ram.sv]
// ----------------------------------------------------------------------------
// fba_ram: generic single-port-write, single-port-read RAM
// One write and one read a cycle; read data is registered.
// ----------------------------------------------------------------------------
module fba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]               wdata,
	input  logic                           re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]               rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

[src/fba_ctrl.sv]
// ----------------------------------------------------------------------------
// fba_ctrl: allocator sequencer
// Walks one command through decode and, as needed, group scan, word read and
// read-modify-write, then hands the result to the output register.
// ----------------------------------------------------------------------------
module fba_ctrl
	import fba_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  fba_stat_t stat,
	output fba_cmd_t  ctl
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_MOD  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load_req = 1'b1;
					state_d      = S_DEC;
				end
			end
			S_DEC: begin
				if (stat.req_noop) begin
					ctl.res_load = 1'b1;
					ctl.res_sel  = RES_NOOP;
					state_d      = S_DONE;
				end else if (stat.is_free) begin
					ctl.rd_entry = 1'b1;
					state_d      = S_MOD;
				end else begin
					ctl.scan_clr = 1'b1;
					state_d      = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.grp_hit) begin
					ctl.rd_found = 1'b1;
					state_d      = S_MOD;
				end else if (stat.grp_last) begin
					ctl.res_load = 1'b1;
					ctl.res_sel  = RES_FULL;
					state_d      = S_DONE;
				end else begin
					ctl.scan_step = 1'b1;
				end
			end
			S_MOD: begin
				ctl.res_load = 1'b1;
				if (stat.is_free) begin
					ctl.mod_free = 1'b1;
					ctl.res_sel  = RES_FREE;
				end else begin
					ctl.mod_alloc = 1'b1;
					ctl.res_sel   = RES_ALLOC;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

[src/fba_dpath.sv]
// ----------------------------------------------------------------------------
// fba_dpath: allocator datapath
// Holds the bitmap RAM, per-word full and written flags, the request and the
// result/output registers; does the group scan and the bit search.
// ----------------------------------------------------------------------------
module fba_dpath
	import fba_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  fba_in_t   in_data,
	input  fba_cmd_t  ctl,
	output fba_stat_t stat,
	output fba_out_t  out_data
);

	fba_in_t                 req_q;
	fba_out_t                res_q, out_q;
	fba_out_t                res_d;
	logic [GRP_W-1:0]        grp_q;
	logic [ADDR_W-1:0]       word_q;
	logic                    rd_vld_q;
	logic [MAP_WORDS-1:0]    full_q;
	logic [MAP_WORDS-1:0]    valid_q;

	logic [GROUPS*GRP_SIZE-1:0] scan_full;
	logic [GRP_SIZE-1:0]     grp_bits;
	logic [GRP_IDX_W-1:0]    grp_enc;
	logic [ADDR_W-1:0]       found_word, entry_word, rd_addr;
	logic [BIT_W-1:0]        entry_bit, free_bit;
	logic [WORD_W-1:0]       rdata, cur_word, fill, chk_word, new_word;
	logic                    new_full, rd_en, wr_en;

	assign entry_word = ADDR_W'(req_q.entry_frame >> BIT_W);
	assign entry_bit  = req_q.entry_frame[BIT_W-1:0];

	// Request decode
	assign stat.is_free  = (req_q.cmd == CMD_FREE);
	assign stat.req_noop = (req_q.cmd == CMD_ALLOC) ? (req_q.entry_frame != '0)
		: ((req_q.entry_frame == '0) || (32'(req_q.entry_frame) >= 32'(NUM_FRAMES)));

	// Group scan over the full-word summary, eight words a cycle
	always_comb begin
		scan_full = '1;
		for (int i = 0; i < SCAN_WORDS; i++)
			scan_full[i] = full_q[i];
		grp_bits = scan_full[grp_q*GRP_SIZE +: GRP_SIZE];
		grp_enc  = '0;
		for (int i = GRP_SIZE - 1; i >= 0; i--) begin
			if (!grp_bits[i])
				grp_enc = GRP_IDX_W'(i);
		end
	end

	assign stat.grp_hit  = ~&grp_bits;
	assign stat.grp_last = (grp_q == GRP_W'(GROUPS - 1));
	assign found_word    = ADDR_W'({grp_q, grp_enc});

	// Bitmap RAM
	assign rd_en   = ctl.rd_entry | ctl.rd_found;
	assign rd_addr = ctl.rd_found ? found_word : entry_word;
	assign wr_en   = ctl.mod_alloc | ctl.mod_free;

	fba_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (wr_en),
		.waddr(word_q),
		.wdata(new_word),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// Bit search and word update; never-written words read as all free
	always_comb begin
		cur_word = rd_vld_q ? rdata : '0;
		fill     = (word_q == LAST_WORD) ? LAST_FILL : '0;
		chk_word = cur_word | fill;
		free_bit = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (!chk_word[b])
				free_bit = BIT_W'(b);
		end
		if (ctl.mod_free)
			new_word = cur_word & ~(WORD_W'(1) << entry_bit);
		else
			new_word = cur_word | (WORD_W'(1) << free_bit);
		new_full = &(new_word | fill);
	end

	// Result beat selection
	always_comb begin
		res_d = '0;
		case (ctl.res_sel)
			RES_NOOP: begin
				res_d.status = STAT_NOOP;
				if (req_q.cmd == CMD_ALLOC)
					res_d.frame_number = req_q.entry_frame;
			end
			RES_FULL: begin
				res_d.status = STAT_FULL;
			end
			RES_ALLOC: begin
				res_d.frame_number = FRAME_W'({word_q, free_bit});
				res_d.present      = 1'b1;
				res_d.writable     = req_q.write_req;
				res_d.user_mode    = ~req_q.kernel_page;
				res_d.status       = STAT_DONE;
			end
			RES_FREE: begin
				res_d.status = STAT_DONE;
			end
			default: begin
				res_d.status = STAT_DONE;
			end
		endcase
	end

	// Control flags: scan pointer, read tag, word summaries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q    <= '0;
			rd_vld_q <= 1'b0;
			full_q   <= '0;
			valid_q  <= '0;
		end else begin
			if (ctl.scan_clr)
				grp_q <= '0;
			else if (ctl.scan_step)
				grp_q <= grp_q + 1'b1;
			if (rd_en)
				rd_vld_q <= valid_q[rd_addr];
			if (wr_en) begin
				full_q[word_q]  <= new_full;
				valid_q[word_q] <= 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (ctl.load_req)
			req_q <= in_data;
		if (rd_en)
			word_q <= rd_addr;
		if (ctl.res_load)
			res_q <= res_d;
		if (ctl.out_load)
			out_q <= res_q;
	end

	assign out_data = out_q;

endmodule
